// ===== rtl/bmsd_pkg.sv =====
package bmsd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int HIST_W     = 4;
    localparam int SLICE_W    = 5;
    localparam int NRES       = 9;
    localparam int SEL_W      = $clog2(NRES);
    localparam int OUT_COL_W  = 10;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

    // row and column offsets of each result slot, in release order
    localparam logic [1:0] DR_OF [NRES] = '{2'd2, 2'd2, 2'd2,
                                           2'd1, 2'd1, 2'd1,
                                           2'd0, 2'd0, 2'd0};
    localparam logic [1:0] DC_OF [NRES] = '{2'd2, 2'd1, 2'd0,
                                           2'd2, 2'd1, 2'd0,
                                           2'd2, 2'd1, 2'd0};

    typedef struct packed {
        logic [NRES-1:0]  pend;
        logic [NRES-1:0]  mark;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } emit_t;

endpackage

// ===== rtl/bmsd_ram.sv =====
module bmsd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmsd_emit.sv =====
module bmsd_emit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  bmsd_pkg::emit_t                 in_entry,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [bmsd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    logic [bmsd_pkg::NRES-1:0]      pend_reg, pend_next, pend_left;
    bmsd_pkg::emit_t                ent_reg;
    logic [bmsd_pkg::SEL_W-1:0]     sel;
    logic                           fire, only_one;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [bmsd_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [bmsd_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;
    logic [bmsd_pkg::ROW_W-1:0]     row_out;
    logic [bmsd_pkg::COL_W-1:0]     col_out;

    always_comb begin
        sel = '0;
        for (int i = bmsd_pkg::NRES - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = bmsd_pkg::SEL_W'(i);
            end
        end
    end

    assign only_one  = (pend_reg & (pend_reg - bmsd_pkg::NRES'(1))) == '0;
    assign fire      = (pend_reg != '0) && (!m_tvalid_reg || m_tready);
    assign pend_left = pend_reg & ~(bmsd_pkg::NRES'(1) << sel);
    assign in_ready  = (pend_reg == '0) || (fire && only_one);

    assign row_out = ent_reg.row - bmsd_pkg::ROW_W'(bmsd_pkg::DR_OF[sel]);
    assign col_out = ent_reg.col - bmsd_pkg::COL_W'(bmsd_pkg::DC_OF[sel]);

    always_comb begin
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (fire) begin
            pend_next = pend_left;
        end
        if (in_valid && in_ready) begin
            pend_next = in_entry.pend;
        end
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = bmsd_pkg::M_TDATA_W'({ent_reg.mark[sel],
                                                  bmsd_pkg::OUT_COL_W'(col_out),
                                                  row_out});
            m_tuser_next  = bmsd_pkg::M_TUSER_W'(only_one);
            m_tlast_next  = sel == bmsd_pkg::SEL_W'(bmsd_pkg::NRES - 1);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (in_valid && in_ready) begin
            ent_reg <= in_entry;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/binary_mask_square_dilation_top.sv =====
// 5x5 binary dilation of a raster-order mask stream.
// s_ channel: one mask bit per beat, rows top to bottom, columns left to right.
// m_ channel: released output pixels with row, column and dilated bit; a beat
// releases nothing until two rows and two columns later, and the last pixel of
// a row or frame releases a burst of up to 9 beats. m_tuser marks the last
// result of one input beat, m_tlast the last pixel of the frame.
// cfg_ channel: index 0 sets the image width, index 1 the image height; write
// only while the stream is idle.
// Path: the input beat is registered in stage 1, its result set then in the
// emitter, and each result in the output register that drives m_tdata.
// Throughput: one input beat per cycle while m_tready is high and each beat
// gives at most one result; a burst of n results holds s_tready low until the
// last is sent. The 1024 x 4 history RAM is read on accept and written as the
// beat leaves stage 1, with a forward of a write made in the cycle of the read.
// Reset: counters go to zero, width and height to 1024, and a clearing pass
// writes zero to all 1024 history RAM entries with s_tready low.
// Stall: a low m_tready holds the output beat; the result queue and then
// s_tready back up behind it, and no beat is lost.
module binary_mask_square_dilation_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bmsd_pkg::S_TDATA_W-1:0]   s_tdata,   // mark_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bmsd_pkg::M_TDATA_W-1:0]   m_tdata,   // out_row, out_col, mark_out
    output logic [bmsd_pkg::M_TUSER_W-1:0]   m_tuser,   // last_of_step
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = bmsd_pkg::COL_W;
    localparam int ROW_W = bmsd_pkg::ROW_W;

    logic [bmsd_pkg::WIDTH_W-1:0]  width_reg;
    logic [bmsd_pkg::HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [COL_W-1:0]              wm1;
    logic [ROW_W-1:0]              hm1;
    logic                          last_col, last_row;
    logic                          accept;

    logic                          clr_busy_reg;
    logic [COL_W-1:0]              clr_addr_reg;

    logic                          s1_valid_reg;
    logic                          s1_mark_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    logic                          s1_last_col_reg, s1_last_row_reg;
    logic                          s1_fwd_hit_reg;
    logic [bmsd_pkg::HIST_W-1:0]   s1_fwd_data_reg;
    logic                          s1_move;

    logic [bmsd_pkg::SLICE_W-1:0]  win_reg [4];
    logic [bmsd_pkg::SLICE_W-1:0]  slice [5];
    logic [bmsd_pkg::HIST_W-1:0]   hist, hist_rd;

    logic                          ram_we;
    logic [COL_W-1:0]              ram_waddr;
    logic [bmsd_pkg::HIST_W-1:0]   ram_wdata;

    bmsd_pkg::emit_t               entry;
    logic                          emit_ready;

    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (width_reg > bmsd_pkg::WIDTH_W'(bmsd_pkg::MAX_WIDTH)) begin
            wm1 = COL_W'(bmsd_pkg::MAX_WIDTH - 1);
        end else begin
            wm1 = COL_W'(width_reg - bmsd_pkg::WIDTH_W'(1));
        end
        hm1 = (height_reg == '0) ? '0 : height_reg - ROW_W'(1);
    end

    assign last_col  = col_reg >= wm1;
    assign last_row  = row_reg >= hm1;
    assign s1_move   = s1_valid_reg && emit_ready;
    assign s_tready  = !clr_busy_reg && (!s1_valid_reg || s1_move);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // stage 1: merge history, build slices and result set
    always_comb begin
        hist = s1_fwd_hit_reg ? s1_fwd_data_reg : hist_rd;
        for (int k = 1; k <= 4; k++) begin
            if (s1_row_reg < ROW_W'(k)) begin
                hist[k-1] = 1'b0;
            end
        end
        slice[0] = {hist, s1_mark_reg};
        for (int k = 1; k <= 4; k++) begin
            slice[k] = (s1_col_reg >= COL_W'(k)) ? win_reg[k-1] : '0;
        end
    end

    always_comb begin
        logic [bmsd_pkg::SLICE_W-1:0] acc;
        logic [bmsd_pkg::SLICE_W-1:0] rmask;
        entry.pend = '0;
        entry.mark = '0;
        entry.row  = s1_row_reg;
        entry.col  = s1_col_reg;
        for (int dr = 0; dr <= 2; dr++) begin
            for (int dc = 0; dc <= 2; dc++) begin
                rmask = bmsd_pkg::SLICE_W'(5'b11111 >> (2 - dr));
                acc   = '0;
                for (int j = 0; j <= dc + 2; j++) begin
                    acc = acc | (slice[j] & rmask);
                end
                entry.mark[(2-dr)*3 + (2-dc)] = acc != '0;
                entry.pend[(2-dr)*3 + (2-dc)] =
                    (s1_row_reg >= ROW_W'(dr)) && (dr == 2 || s1_last_row_reg) &&
                    (s1_col_reg >= COL_W'(dc)) && (dc == 2 || s1_last_col_reg);
            end
        end
    end

    assign ram_we    = clr_busy_reg || s1_move;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wdata = clr_busy_reg ? '0 : slice[0][bmsd_pkg::HIST_W-1:0];

    bmsd_ram #(
        .WIDTH (bmsd_pkg::HIST_W),
        .DEPTH (bmsd_pkg::MAX_WIDTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (hist_rd)
    );

    bmsd_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_entry (entry),
        .in_ready (emit_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= bmsd_pkg::WIDTH_RESET;
            height_reg   <= bmsd_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bmsd_pkg::REG_IMAGE_WIDTH:
                        width_reg <= cfg_data[bmsd_pkg::WIDTH_W-1:0];
                    bmsd_pkg::REG_IMAGE_HEIGHT:
                        height_reg <= cfg_data[bmsd_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(bmsd_pkg::MAX_WIDTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                win_reg[3] <= win_reg[2];
                win_reg[2] <= win_reg[1];
                win_reg[1] <= win_reg[0];
                win_reg[0] <= slice[0];
            end
        end
        if (accept) begin
            s1_mark_reg     <= s_tdata[0];
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            // forward the history written by the beat leaving stage 1
            s1_fwd_hit_reg  <= s1_move && (s1_col_reg == col_reg);
            s1_fwd_data_reg <= slice[0][bmsd_pkg::HIST_W-1:0];
        end
    end

endmodule
